// File: sv/apool2_pkg.sv
// ----------------------------------------------------------------------------
// apool2_pkg
// Widths, register indexes, reset values and types shared by the 2x2
// average pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package apool2_pkg;

   // Configuration register widths
   localparam int MAP_SIDE_W      = 7;
   localparam int POOLED_SIDE_W   = 6;
   localparam int CHANNEL_COUNT_W = 5;
   localparam int CSR_DATA_W      = 7;
   localparam int CSR_INDEX_W     = 2;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_SIDE      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POOLED_SIDE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Register reset values
   localparam logic [MAP_SIDE_W-1:0]      MAP_SIDE_RESET      = 7'd24;
   localparam logic [POOLED_SIDE_W-1:0]   POOLED_SIDE_RESET   = 6'd12;
   localparam logic [CHANNEL_COUNT_W-1:0] CHANNEL_COUNT_RESET = 5'd4;

   // Legal limits of the raw registers
   localparam logic [MAP_SIDE_W-1:0]      MIN_MAP_SIDE = 7'd2;
   localparam logic [CHANNEL_COUNT_W-1:0] MAX_CHANNELS = 5'd16;
   localparam int                         CHAN_POS_W   = 4;

   // Datapath widths. Pair sums and stored pairs wrap at ten bits: the
   // rounded mean depends only on the window sum modulo 1024, and a pair
   // built across a mid-map register change can leave the nine-bit range.
   localparam int PIXEL_W = 8;
   localparam int PAIR_W  = 10;
   localparam int SUM_W   = 10;

   // Output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef struct packed {
      logic                      end_of_tensor;
      logic                      end_of_map;
      logic signed [PIXEL_W-1:0] average;
   } result_type;

endpackage

`default_nettype wire

// File: sv/apool2_ram.sv
// ----------------------------------------------------------------------------
// apool2_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module apool2_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: sv/avg_pool_2x2_round_even.sv
// ----------------------------------------------------------------------------
// avg_pool_2x2_round_even
// 2x2 stride-2 average pooling of signed 8-bit maps, rounded half to even.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ stream in channel-major, row-major raster order,
// one item per cycle at full rate. Each even row leaves horizontal pair sums
// in a line store RAM, one entry per window column; the bottom-right pixel
// of a window reads its entry back and the rounded mean leaves on rsp_.
// The completing pixel's line store read is registered alongside its pair
// sum; the sum and rounding follow, and the mean is written to the queue.
// rsp_tlast marks the last mean of a map, rsp_tuser the last of the tensor.
// Throughput is one pixel per cycle while req_tready is high, set by the
// single read and single write port of the line store, never needed twice in a cycle.
// A four-entry output queue lets pixels keep coming while results wait;
// req_tready drops only when the queue and the result in flight fill it.
// Reset restores the register defaults (24, 12, 4), clears the positions
// and empties the queue; the line store needs no clearing pass. The user
// must write the csr_ port only while no item is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module avg_pool_2x2_round_even
   import apool2_pkg::*;
#(
   parameter int MAX_MAP_SIDE = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Pixel input
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [PIXEL_W-1:0]     req_tdata,   // [7:0] pixel
   // Pooled output
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [PIXEL_W-1:0]     rsp_tdata,   // [7:0] average
   output logic                        rsp_tlast,   // end_of_map
   output logic      [0:0]             rsp_tuser,   // [0] end_of_tensor
   // Configuration
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int POS_W   = $clog2(MAX_MAP_SIDE);
   localparam int SLOT_W  = POS_W - 1;
   localparam int DEPTH   = MAX_MAP_SIDE / 2;
   localparam int SIDE_W  = ($clog2(MAX_MAP_SIDE + 1) > MAP_SIDE_W) ?
                            $clog2(MAX_MAP_SIDE + 1) : MAP_SIDE_W;
   localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_MAP_SIDE);

   // Configuration registers
   logic [MAP_SIDE_W-1:0]      map_side_ff;
   logic [POOLED_SIDE_W-1:0]   pooled_side_ff;
   logic [CHANNEL_COUNT_W-1:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_side_ff      <= MAP_SIDE_RESET;
         pooled_side_ff   <= POOLED_SIDE_RESET;
         channel_count_ff <= CHANNEL_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_SIDE:      map_side_ff      <= csr_wdata[MAP_SIDE_W-1:0];
            CSR_POOLED_SIDE:   pooled_side_ff   <= csr_wdata[POOLED_SIDE_W-1:0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHANNEL_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped geometry
   logic [SIDE_W-1:0]          side;
   logic [SIDE_W-1:0]          half_side;
   logic [SIDE_W-1:0]          pooled;
   logic [SIDE_W-1:0]          span;
   logic [CHANNEL_COUNT_W-1:0] chans;

   always_comb begin
      if (map_side_ff < MIN_MAP_SIDE) begin
         side = SIDE_W'(MIN_MAP_SIDE);
      end else if (SIDE_W'(map_side_ff) > SIDE_MAX) begin
         side = SIDE_MAX;
      end else begin
         side = SIDE_W'(map_side_ff);
      end
      half_side = side >> 1;
      if (pooled_side_ff == '0) begin
         pooled = SIDE_W'(1);
      end else if (SIDE_W'(pooled_side_ff) > half_side) begin
         pooled = half_side;
      end else begin
         pooled = SIDE_W'(pooled_side_ff);
      end
      span = pooled << 1;
      if (channel_count_ff == '0) begin
         chans = CHANNEL_COUNT_W'(1);
      end else if (channel_count_ff > MAX_CHANNELS) begin
         chans = MAX_CHANNELS;
      end else begin
         chans = channel_count_ff;
      end
   end

   // Raster position and pair sum
   logic [POS_W-1:0]      col_ff, col_in;
   logic [POS_W-1:0]      row_ff, row_in;
   logic [CHAN_POS_W-1:0] chan_ff, chan_in;
   logic signed [PAIR_W-1:0] pair_sum_ff, pair_sum_in;

   logic                     accept;
   logic signed [PAIR_W-1:0] pixel_ext;
   logic signed [PAIR_W-1:0] pair;
   logic [SIDE_W-1:0]        col_ext, row_ext;
   logic                     in_window;
   logic                     col_odd, row_odd;
   logic                     store_wr, store_rd;
   logic [SLOT_W-1:0]        slot;
   logic                     last_of_map, last_of_tensor;

   assign accept    = req_tvalid && req_tready;
   assign pixel_ext = PAIR_W'($signed(req_tdata));
   assign pair      = pair_sum_ff + pixel_ext;
   assign col_ext   = SIDE_W'(col_ff);
   assign row_ext   = SIDE_W'(row_ff);
   assign in_window = (col_ext < span) && (row_ext < span);
   assign col_odd   = col_ff[0];
   assign row_odd   = row_ff[0];
   assign slot      = col_ff[POS_W-1:1];
   assign store_wr  = accept && in_window && col_odd && !row_odd;
   assign store_rd  = accept && in_window && col_odd && row_odd;

   assign last_of_map    = (col_ext == span - SIDE_W'(1)) && (row_ext == span - SIDE_W'(1));
   assign last_of_tensor = last_of_map &&
                           (CHANNEL_COUNT_W'(chan_ff) == chans - CHANNEL_COUNT_W'(1));

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      chan_in     = chan_ff;
      pair_sum_in = pair_sum_ff;
      if (accept) begin
         if (in_window) begin
            pair_sum_in = col_odd ? pair : pixel_ext;
         end
         if (col_ext + SIDE_W'(1) < side) begin
            col_in = col_ff + POS_W'(1);
         end else begin
            col_in = '0;
            if (row_ext + SIDE_W'(1) < side) begin
               row_in = row_ff + POS_W'(1);
            end else begin
               row_in = '0;
               if (CHANNEL_COUNT_W'(chan_ff) + CHANNEL_COUNT_W'(1) < chans) begin
                  chan_in = chan_ff + CHAN_POS_W'(1);
               end else begin
                  chan_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         chan_ff     <= '0;
         pair_sum_ff <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         chan_ff     <= chan_in;
         pair_sum_ff <= pair_sum_in;
      end
   end

   // Line store of even-row pair sums. A slot is written on an even row and
   // read only on a later odd row, so a read never meets a write in flight.
   logic [PAIR_W-1:0] store_rd_data;

   apool2_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (slot),
      .wr_data (pair),
      .rd_en   (store_rd),
      .rd_addr (slot),
      .rd_data (store_rd_data)
   );

   // Completion stage, aligned with the line store read data
   logic                     s1_valid_ff;
   logic signed [PAIR_W-1:0] s1_pair_ff;
   logic                     s1_eom_ff, s1_eot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= store_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (store_rd) begin
         s1_pair_ff <= pair;
         s1_eom_ff  <= last_of_map;
         s1_eot_ff  <= last_of_tensor;
      end
   end

   // Divide by four: floor shift, then round the remainder half to even.
   logic signed [SUM_W-1:0]   window_sum;
   logic signed [PIXEL_W-1:0] quotient;
   logic                      round_up;
   result_type                s1_result;

   assign window_sum = SUM_W'($signed(store_rd_data)) + SUM_W'(s1_pair_ff);
   assign quotient   = window_sum[SUM_W-1:2];
   assign round_up   = (window_sum[1:0] == 2'd3) ||
                       ((window_sum[1:0] == 2'd2) && quotient[0]);

   always_comb begin
      s1_result.average       = quotient + PIXEL_W'(round_up);
      s1_result.end_of_map    = s1_eom_ff;
      s1_result.end_of_tensor = s1_eot_ff;
   end

   // Output queue
   result_type             queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_CNT_W-1:0] occupancy;
   logic                   pop;
   result_type             head;

   assign pop       = rsp_tvalid && rsp_tready;
   assign occupancy = count_ff + QUEUE_CNT_W'(s1_valid_ff);
   // The item accepted now still fits once the result in flight lands.
   assign req_tready = occupancy < QUEUE_CNT_W'(QUEUE_DEPTH);

   always_comb begin
      count_in = count_ff;
      if (s1_valid_ff && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (!s1_valid_ff && pop) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (s1_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         queue_ff[wr_ptr_ff] <= s1_result;
      end
   end

   assign head         = queue_ff[rd_ptr_ff];
   assign rsp_tvalid   = count_ff != '0;
   assign rsp_tdata    = head.average;
   assign rsp_tlast    = head.end_of_map;
   assign rsp_tuser[0] = head.end_of_tensor;

endmodule

`default_nettype wire

// File: tb/tb_avg_pool_2x2_round_even.sv
// ----------------------------------------------------------------------------
// tb_avg_pool_2x2_round_even
// Self-checking stream testbench for the 2x2 average pooling block.
// ----------------------------------------------------------------------------
// A queue of pixels is filled in phases, each phase opening with register
// writes while the block is idle. A clocked driver feeds the req_ stream
// with random gaps, and the rsp_ side stalls at random. A clocked monitor
// keeps its own copy of the pooling state: each accepted pixel updates it,
// and every window it completes queues an expected mean with its flags.
// Each accepted result is checked against the oldest expected mean. Most
// phases finish the current tensor and add whole small tensors; the rest
// stop partway, so later writes land mid-tensor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_avg_pool_2x2_round_even;
   import apool2_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int MAX_SIDE       = 64;
   localparam int RANDOM_ITEMS   = 1450;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_CYCLES = 500000;
   localparam int PRINT_LIMIT    = 40;

   // Index 3 has no register behind it; writes there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // Six windows for a 2x2 map: both extremes, then remainders that round
   // half to even (up and down, positive and negative) and a plain round-up.
   localparam logic [PIXEL_W-1:0] ROUNDING_WINDOWS [24] = '{
      8'h80, 8'h80, 8'h80, 8'h80,
      8'h7f, 8'h7f, 8'h7f, 8'h7f,
      8'h01, 8'h01, 8'h00, 8'h00,
      8'h03, 8'h03, 8'h00, 8'h00,
      8'hff, 8'hff, 8'h00, 8'h00,
      8'h03, 8'h00, 8'h00, 8'h00
   };

   logic clock;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIXEL_W-1:0]     req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_tdata;
   logic                   rsp_tlast;
   logic [0:0]             rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_MAP_SIDE;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   avg_pool_2x2_round_even #(
      .MAX_MAP_SIDE(MAX_SIDE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the registers and of the pooling state.
   logic [MAP_SIDE_W-1:0]      cfg_map_side = MAP_SIDE_RESET;
   logic [POOLED_SIDE_W-1:0]   cfg_pooled   = POOLED_SIDE_RESET;
   logic [CHANNEL_COUNT_W-1:0] cfg_channels = CHANNEL_COUNT_RESET;
   logic [5:0]                 col_pos  = '0;
   logic [5:0]                 row_pos  = '0;
   logic [CHAN_POS_W-1:0]      chan_pos = '0;
   logic signed [PAIR_W-1:0]   pair_acc = '0;
   logic signed [PAIR_W-1:0]   line_pairs [MAX_SIDE/2];

   logic [PIXEL_W-1:0] pending_pixels [$];
   result_type         expected_means [$];
   int                 pixels_queued  = 0;
   int                 pixels_taken   = 0;
   int                 mismatch_count = 0;
   bit                 steady         = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD/2) clock = ~clock;
   end

   function automatic bit take_break();
      return !steady && ($urandom_range(0, 99) < 9);
   endfunction

   function automatic logic [PIXEL_W-1:0] next_pixel();
      if ($urandom_range(0, 99) < 15) begin
         case ($urandom_range(0, 3))
            0: return 8'h80;
            1: return 8'h7f;
            2: return 8'h00;
            default: return 8'hff;
         endcase
      end
      return PIXEL_W'($urandom_range(0, 255));
   endfunction

   // Effective sizes after the block's clamping of out-of-range registers.
   function automatic void clamp_dims(output int side, output int pooled, output int chans);
      side = int'(cfg_map_side);
      if (side < int'(MIN_MAP_SIDE)) side = int'(MIN_MAP_SIDE);
      if (side > MAX_SIDE) side = MAX_SIDE;
      pooled = int'(cfg_pooled);
      if (pooled < 1) pooled = 1;
      if (pooled > side / 2) pooled = side / 2;
      chans = int'(cfg_channels);
      if (chans < 1) chans = 1;
      if (chans > int'(MAX_CHANNELS)) chans = int'(MAX_CHANNELS);
   endfunction

   // Raster advance; a position at or past the bounds wraps on its next step.
   function automatic void step_position(inout int col, inout int row, inout int chan,
                                         input int side, input int chans);
      if (col + 1 < side) begin
         col++;
      end else begin
         col = 0;
         if (row + 1 < side) begin
            row++;
         end else begin
            row = 0;
            chan = (chan + 1 < chans) ? chan + 1 : 0;
         end
      end
   endfunction

   task automatic pool_pixel(input logic [PIXEL_W-1:0] px);
      int side, pooled, chans, span, col, row, chan, pix, pair, total, q;
      result_type mean;
      clamp_dims(side, pooled, chans);
      span = 2 * pooled;
      col  = int'(col_pos);
      row  = int'(row_pos);
      chan = int'(chan_pos);
      pix  = int'($signed(px));
      if (col < span && row < span) begin
         if (col % 2 == 0) begin
            pair_acc = pix[PAIR_W-1:0];
         end else begin
            pair = int'(pair_acc) + pix;
            pair_acc = pair[PAIR_W-1:0];
            if (row % 2 == 0) begin
               line_pairs[col / 2] = pair[PAIR_W-1:0];
            end else begin
               total = int'(line_pairs[col / 2]) + pair;
               // Floor by the arithmetic shift, then round the remainder
               // half to even.
               q = total >>> 2;
               if ((total & 3) == 3 || ((total & 3) == 2 && q[0])) q++;
               mean.average       = q[PIXEL_W-1:0];
               mean.end_of_map    = (col == span - 1) && (row == span - 1);
               mean.end_of_tensor = mean.end_of_map && (chan == chans - 1);
               expected_means.push_back(mean);
            end
         end
      end
      step_position(col, row, chan, side, chans);
      col_pos  = col[5:0];
      row_pos  = row[5:0];
      chan_pos = chan[CHAN_POS_W-1:0];
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s, got %0d, expected %0d", $time, what, got, want);
   endtask

   // Driver: a new item is offered only once the previous one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pixels.size() != 0 && !take_break()) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_pixels.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !take_break();
   end

   // Monitor: predict from accepted pixels, then check accepted results.
   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pool_pixel(req_tdata);
            pixels_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               report_mismatch("result with nothing expected", int'($signed(rsp_tdata)), 0);
            end else begin
               want = expected_means.pop_front();
               if (rsp_tdata !== want.average)
                  report_mismatch("average", int'($signed(rsp_tdata)),
                                  int'(want.average));
               if (rsp_tlast !== want.end_of_map)
                  report_mismatch("end_of_map", int'(rsp_tlast), int'(want.end_of_map));
               if (rsp_tuser[0] !== want.end_of_tensor)
                  report_mismatch("end_of_tensor", int'(rsp_tuser[0]),
                                  int'(want.end_of_tensor));
            end
         end
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_MAP_SIDE:      cfg_map_side = val[MAP_SIDE_W-1:0];
         CSR_POOLED_SIDE:   cfg_pooled   = val[POOLED_SIDE_W-1:0];
         CSR_CHANNEL_COUNT: cfg_channels = val[CHANNEL_COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // Wait until every pixel is taken and every mean has arrived, then give
   // a pixel that completes no window time to leave the pipeline.
   task automatic drain_results();
      do @(posedge clock);
      while (pixels_taken != pixels_queued || expected_means.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A negative count finishes the current tensor and adds that many whole
   // tensors; large tensors get a partial run instead.
   task automatic run_phase(input logic [MAP_SIDE_W-1:0] m, input logic [POOLED_SIDE_W-1:0] p,
                            input logic [CHANNEL_COUNT_W-1:0] c, input bit [2:0] which,
                            input int count);
      int side, pooled, chans, col, row, chan, n;
      if (which[0]) write_reg(CSR_MAP_SIDE, m);
      if (which[1]) write_reg(CSR_POOLED_SIDE, {1'($urandom_range(0, 1)), p});
      if (which[2]) write_reg(CSR_CHANNEL_COUNT, {2'($urandom_range(0, 3)), c});
      n = count;
      if (count < 0) begin
         clamp_dims(side, pooled, chans);
         if (side * side * chans > 200) begin
            n = $urandom_range(20, 120);
         end else begin
            col  = int'(col_pos);
            row  = int'(row_pos);
            chan = int'(chan_pos);
            n    = 0;
            while (col != 0 || row != 0 || chan != 0) begin
               step_position(col, row, chan, side, chans);
               n++;
            end
            n += -count * side * side * chans;
         end
      end
      repeat (n) begin
         pending_pixels.push_back(next_pixel());
         pixels_queued++;
      end
      drain_results();
   endtask

   initial begin
      logic [MAP_SIDE_W-1:0]      m;
      logic [POOLED_SIDE_W-1:0]   p;
      logic [CHANNEL_COUNT_W-1:0] c;
      bit [2:0]                   mask;
      int                         cnt;
      int                         phase;
      foreach (line_pairs[i]) line_pairs[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Smallest shape: every four pixels make one window that ends both
      // the map and the tensor.
      write_reg(CSR_MAP_SIDE, 7'd2);
      write_reg(CSR_POOLED_SIDE, 7'd1);
      write_reg(CSR_CHANNEL_COUNT, 7'd1);
      for (int i = 0; i < 24; i++) begin
         pending_pixels.push_back(ROUNDING_WINDOWS[i]);
         pixels_queued++;
      end
      drain_results();

      // The first two rows of a full-size map fill every line store entry,
      // so later mid-map changes never read an unwritten one.
      steady = 1'b1;
      run_phase(7'd64, 6'd32, 5'd1, 3'b111, 128);
      steady = 1'b0;
      run_phase(7'd2, 6'd63, 5'd16, 3'b111, -1);
      run_phase(7'd127, 6'd0, 5'd31, 3'b111, 40);

      phase = 0;
      while (pixels_queued < RANDOM_ITEMS) begin
         steady = (phase >= 8 && phase < 12);
         if ($urandom_range(0, 9) == 0) write_reg(CSR_SPARE, CSR_DATA_W'($urandom));
         case ($urandom_range(0, 9))
            0: m = MAP_SIDE_W'($urandom_range(0, 1));
            1: m = MAP_SIDE_W'($urandom_range(9, 64));
            2: m = MAP_SIDE_W'($urandom_range(65, 127));
            default: m = MAP_SIDE_W'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 7))
            0: p = POOLED_SIDE_W'($urandom_range(0, 63));
            1: p = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd63;
            2: p = ($urandom_range(0, 1) == 0) ? 6'd32 : 6'd33;
            default: p = POOLED_SIDE_W'($urandom_range(1, 4));
         endcase
         if ($urandom_range(0, 9) < 4) c = CHANNEL_COUNT_W'($urandom_range(0, 31));
         else c = CHANNEL_COUNT_W'($urandom_range(1, 3));
         mask = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7)) : 3'b111;
         cnt  = ($urandom_range(0, 9) < 7) ? -int'($urandom_range(1, 2))
                                           : int'($urandom_range(5, 90));
         run_phase(m, p, c, mask, cnt);
         phase++;
      end
      steady = 1'b0;
      drain_results();

      if (mismatch_count == 0 && expected_means.size() == 0) begin
         $display("** avg_pool_2x2_round_even: PASSED **");
      end else begin
         $display("** avg_pool_2x2_round_even: FAILED **");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("timeout after %0d cycles", TIMEOUT_CYCLES);
      $display("** avg_pool_2x2_round_even: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
